// File: rtl/sdpg_pkg.sv
package sdpg_pkg;

    localparam int TICK_W   = 20;
    localparam int RATE_W   = 17;
    localparam int PERIOD_W = 16;
    localparam int POS_W    = 32;
    localparam int MODE_W   = 3;
    localparam int CFG_W    = 20;
    localparam int CIDX_W   = 3;
    localparam int QUO_W    = TICK_W;
    localparam int DIV_W    = RATE_W + 1;
    localparam int CNT_W    = $clog2(QUO_W);

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK     = 3'd0,
        MODE_SET_RATE = 3'd1,
        MODE_JOG      = 3'd2,
        MODE_STOP     = 3'd3,
        MODE_ENABLE   = 3'd4,
        MODE_LOAD_POS = 3'd5,
        MODE_ACK_DONE = 3'd6
    } t_mode;

    localparam logic [CIDX_W-1:0] CFG_TIMER_RUN = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_TICK_RATE = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_MIN_HALF  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MAX_HALF  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_MAX_RATE  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_DIR_INV   = 3'd5;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] tick_rate;
        logic [RATE_W-1:0] rate;
    } t_div_req;

endpackage

// File: rtl/sdpg_div.sv
module sdpg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sdpg_pkg::t_div_req            i_req,
    input  logic [sdpg_pkg::PERIOD_W-1:0] i_min_half,
    input  logic [sdpg_pkg::PERIOD_W-1:0] i_max_half,
    output logic [sdpg_pkg::PERIOD_W-1:0] o_half,
    output logic                          o_done
);
    import sdpg_pkg::*;

    typedef enum logic [2:0] {
        D_IDLE  = 3'b001,
        D_RUN   = 3'b010,
        D_CLAMP = 3'b100
    } t_dstate;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUO_W - 1);
    localparam int V_W = QUO_W + 1;

    t_dstate               r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [QUO_W-1:0]      r_quo, n_quo;
    logic [DIV_W-1:0]      r_rem, n_rem;
    logic [DIV_W-1:0]      r_div, n_div;
    logic [RATE_W-1:0]     r_rate, n_rate;
    logic [PERIOD_W-1:0]   r_half, n_half;
    logic                  r_done, n_done;

    logic [DIV_W:0]        rem_s;
    logic [DIV_W+1:0]      diff;
    logic                  ge;
    logic [V_W-1:0]        min_x, max_x, v;
    logic                  lt_min, gt_max, rnd;

    always_comb begin
        rem_s  = {r_rem, r_quo[QUO_W-1]};
        diff   = {1'b0, rem_s} - {2'b00, r_div};
        ge     = !diff[DIV_W+1];
        min_x  = V_W'(i_min_half);
        max_x  = V_W'(i_max_half);
        lt_min = V_W'(r_quo) < min_x;
        gt_max = (V_W'(r_quo) > max_x) || ((V_W'(r_quo) == max_x) && (r_rem != '0));
        rnd    = r_rem >= DIV_W'(r_rate);
        if (lt_min) begin
            v = min_x;
        end else if (gt_max) begin
            v = max_x;
        end else begin
            v = V_W'(r_quo) + V_W'(rnd);
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_div   = r_div;
        n_rate  = r_rate;
        n_half  = r_half;
        n_done  = 1'b0;
        case (r_state)
            D_IDLE: begin
                if (i_req.start) begin
                    n_quo   = i_req.tick_rate;
                    n_rem   = '0;
                    n_rate  = i_req.rate;
                    n_div   = {i_req.rate, 1'b0};
                    n_cnt   = '0;
                    n_state = D_RUN;
                end
            end
            D_RUN: begin
                // one quotient bit per cycle
                n_rem = ge ? diff[DIV_W-1:0] : rem_s[DIV_W-1:0];
                n_quo = {r_quo[QUO_W-2:0], ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = D_CLAMP;
                end
            end
            D_CLAMP: begin
                n_half  = (v > max_x) ? i_max_half : v[PERIOD_W-1:0];
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt  <= n_cnt;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_rate <= n_rate;
        r_half <= n_half;
    end

    assign o_half = r_half;
    assign o_done = r_done;

endmodule

// File: rtl/step_dir_pulse_generator_unit.sv
// tick, stop, enable, position, acknowledge and zero-rate requests give their
//   result in the cycle after acceptance, one request per cycle unless the
//   output is stalled; rate and jog requests with a nonzero clamped rate pass
//   through the bit-serial divider (20 quotient bits, one per cycle), clamp and
//   update, and no new request is accepted until such a request has finished
// synchronous active-low reset returns control state and configuration to defaults
module step_dir_pulse_generator_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [sdpg_pkg::CIDX_W-1:0]   i_cfg_idx,
    input  logic [sdpg_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [sdpg_pkg::MODE_W-1:0]   i_mode,
    input  logic signed [sdpg_pkg::RATE_W-1:0] i_rate_sps,
    input  logic signed [sdpg_pkg::POS_W-1:0]  i_jog_steps,
    input  logic                          i_enable_value,
    input  logic signed [sdpg_pkg::POS_W-1:0]  i_position_value,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_step_out,
    output logic                          o_dir_out,
    output logic                          o_drive_enabled,
    output logic signed [sdpg_pkg::POS_W-1:0]  o_position,
    output logic                          o_jog_active,
    output logic                          o_jog_done,
    output logic                          o_pulsing
);
    import sdpg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state              r_state, n_state;

    logic                r_timer_run;
    logic [TICK_W-1:0]   r_tick_rate;
    logic [PERIOD_W-1:0] r_min_half, r_max_half, r_max_rate;
    logic                r_dir_inv;

    logic                r_step, n_step;
    logic                r_pulse, n_pulse;
    logic                r_dir, n_dir;
    logic [PERIOD_W-1:0] r_half, n_half;
    logic [PERIOD_W-1:0] r_cd, n_cd;
    logic [POS_W-1:0]    r_jog_rem, n_jog_rem;
    logic                r_jog_mode, n_jog_mode;
    logic                r_jog_done, n_jog_done;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_drv, n_drv;

    logic                r_out_valid, n_out_valid;
    logic                r_o_step, r_o_dir, r_o_drv, r_o_jact, r_o_jdone, r_o_pulse;
    logic [POS_W-1:0]    r_o_pos;

    logic                out_free, acc, load;
    logic                rneg, jneg;
    logic [RATE_W-1:0]   rmag, mag, mag_c;
    logic [POS_W-1:0]    jmag;
    logic                neg;
    t_div_req            div_req;
    logic [PERIOD_W-1:0] div_half;
    logic                div_done;
    logic [PERIOD_W-1:0] hp;
    logic                apply_rate;

    sdpg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_min_half (r_min_half),
        .i_max_half (r_max_half),
        .o_half     (div_half),
        .o_done     (div_done)
    );

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign acc      = i_valid && o_ready;

    always_comb begin
        rneg  = i_rate_sps[RATE_W-1];
        rmag  = rneg ? (RATE_W'(0) - i_rate_sps) : i_rate_sps;
        jneg  = i_jog_steps[POS_W-1];
        jmag  = jneg ? (POS_W'(0) - i_jog_steps) : i_jog_steps;
        mag   = ((t_mode'(i_mode) == MODE_JOG) && (rmag == '0)) ? RATE_W'(1) : rmag;
        mag_c = (mag > RATE_W'(r_max_rate)) ? RATE_W'(r_max_rate) : mag;
        neg   = (t_mode'(i_mode) == MODE_JOG) ? jneg : rneg;
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_pulse    = r_pulse;
        n_dir      = r_dir;
        n_half     = r_half;
        n_cd       = r_cd;
        n_jog_rem  = r_jog_rem;
        n_jog_mode = r_jog_mode;
        n_jog_done = r_jog_done;
        n_pos      = r_pos;
        n_drv      = r_drv;
        load       = 1'b0;
        apply_rate = 1'b0;
        hp         = '0;
        div_req.start     = 1'b0;
        div_req.tick_rate = r_tick_rate;
        div_req.rate      = mag_c;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    load = 1'b1;
                    case (t_mode'(i_mode))
                        MODE_TICK: begin
                            if (r_timer_run && r_drv && r_pulse && (r_half != '0)) begin
                                if (r_cd > PERIOD_W'(1)) begin
                                    n_cd = r_cd - 1'b1;
                                end else begin
                                    n_cd   = r_half;
                                    n_step = !r_step;
                                    if (!r_step) begin
                                        n_pos = r_dir ? (r_pos + 1'b1) : (r_pos - 1'b1);
                                        if (r_jog_mode && (r_jog_rem != '0)) begin
                                            n_jog_rem = r_jog_rem - 1'b1;
                                            if (r_jog_rem == POS_W'(1)) begin
                                                n_pulse    = 1'b0;
                                                n_step     = 1'b0;
                                                n_jog_done = 1'b1;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        MODE_SET_RATE, MODE_JOG: begin
                            if ((t_mode'(i_mode) == MODE_JOG) && (i_jog_steps == '0)) begin
                                n_pulse    = 1'b0;
                                n_jog_mode = 1'b0;
                                n_jog_rem  = '0;
                                n_jog_done = 1'b0;
                                n_half     = '0;
                                n_cd       = '0;
                                n_step     = 1'b0;
                            end else begin
                                if (t_mode'(i_mode) == MODE_JOG) begin
                                    n_jog_rem  = jmag;
                                    n_jog_mode = 1'b1;
                                    n_jog_done = 1'b0;
                                end
                                if (mag_c == '0) begin
                                    n_dir      = 1'b1;
                                    apply_rate = 1'b1;
                                end else begin
                                    n_dir         = (neg == r_dir_inv);
                                    load          = 1'b0;
                                    div_req.start = 1'b1;
                                    n_state       = S_DIV;
                                end
                            end
                        end
                        MODE_STOP: begin
                            n_pulse    = 1'b0;
                            n_jog_mode = 1'b0;
                            n_jog_rem  = '0;
                            n_jog_done = 1'b0;
                            n_half     = '0;
                            n_cd       = '0;
                            n_step     = 1'b0;
                        end
                        MODE_ENABLE: begin
                            n_drv = i_enable_value;
                            if (!i_enable_value) begin
                                n_step = 1'b0;
                                n_cd   = r_half;
                            end
                        end
                        MODE_LOAD_POS: begin
                            n_pos = i_position_value;
                        end
                        MODE_ACK_DONE: begin
                            if (r_jog_done) begin
                                n_jog_done = 1'b0;
                                n_jog_mode = 1'b0;
                                n_jog_rem  = '0;
                                n_dir      = 1'b1;
                                apply_rate = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    hp         = div_half;
                    apply_rate = 1'b1;
                    load       = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (apply_rate) begin
            if (hp == '0) begin
                n_half  = '0;
                n_cd    = '0;
                n_pulse = 1'b0;
                n_step  = 1'b0;
            end else if (!r_pulse) begin
                n_half  = hp;
                n_cd    = hp;
                n_pulse = 1'b1;
            end else begin
                n_half = hp;
                n_cd   = (r_cd > hp) ? hp : r_cd;
            end
        end

        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_timer_run <= 1'b0;
            r_tick_rate <= TICK_W'(40000);
            r_min_half  <= PERIOD_W'(2);
            r_max_half  <= PERIOD_W'(65535);
            r_max_rate  <= PERIOD_W'(10000);
            r_dir_inv   <= 1'b0;
            r_step      <= 1'b0;
            r_pulse     <= 1'b0;
            r_dir       <= 1'b1;
            r_half      <= '0;
            r_cd        <= '0;
            r_jog_rem   <= '0;
            r_jog_mode  <= 1'b0;
            r_jog_done  <= 1'b0;
            r_pos       <= '0;
            r_drv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_pulse     <= n_pulse;
            r_dir       <= n_dir;
            r_half      <= n_half;
            r_cd        <= n_cd;
            r_jog_rem   <= n_jog_rem;
            r_jog_mode  <= n_jog_mode;
            r_jog_done  <= n_jog_done;
            r_pos       <= n_pos;
            r_drv       <= n_drv;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TIMER_RUN: r_timer_run <= i_cfg_data[0];
                    CFG_TICK_RATE: r_tick_rate <= i_cfg_data[TICK_W-1:0];
                    CFG_MIN_HALF:  r_min_half  <= i_cfg_data[PERIOD_W-1:0];
                    CFG_MAX_HALF:  r_max_half  <= i_cfg_data[PERIOD_W-1:0];
                    CFG_MAX_RATE:  r_max_rate  <= i_cfg_data[PERIOD_W-1:0];
                    CFG_DIR_INV:   r_dir_inv   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_step  <= n_step;
            r_o_dir   <= n_dir;
            r_o_drv   <= n_drv;
            r_o_pos   <= n_pos;
            r_o_jact  <= n_jog_mode && (n_jog_rem != '0);
            r_o_jdone <= n_jog_done;
            r_o_pulse <= n_pulse;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_step_out      = r_o_step;
    assign o_dir_out       = r_o_dir;
    assign o_drive_enabled = r_o_drv;
    assign o_position      = r_o_pos;
    assign o_jog_active    = r_o_jact;
    assign o_jog_done      = r_o_jdone;
    assign o_pulsing       = r_o_pulse;

endmodule
